// ===== hdl/rgbh_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbh_pkg
// Shared widths, constants and types for the rgb to hsv pixel pipeline.
// ----------------------------------------------------------------------------
package rgbh_pkg;

	localparam int CH_W    = 8;
	localparam int IDX_W   = 6;
	localparam int HUE_W   = 9;
	localparam int SAT_W   = 7;
	localparam int VAL_W   = 15;

	// divider remainder holds up to 420 * 255
	localparam int REM_W     = 17;
	localparam int DIV_STEPS = 9;

	// value accumulator holds up to 255 * 255 * 100
	localparam int ACC_W     = 23;
	localparam int PROD_W    = 48;

	localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
	localparam logic [HUE_W-1:0] BASE_RED   = 9'd360;
	localparam logic [HUE_W-1:0] BASE_GREEN = 9'd120;
	localparam logic [HUE_W-1:0] BASE_BLUE  = 9'd240;
	localparam logic [5:0]       SIXTY      = 6'd60;
	localparam logic [6:0]       PCT_SCALE  = 7'd100;

	// reciprocal of 255 scaled by 2^31, exact for products below 2^31 / 127
	localparam logic [23:0]      DIV255_MUL   = 24'd8421505;
	localparam int               DIV255_SHIFT = 31;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

endpackage

// ===== hdl/rgbh_if.sv =====
// ----------------------------------------------------------------------------
// rgbh channel interfaces
// Valid/ready channels for the incoming pixel beat and the outgoing hsv beat.
// ----------------------------------------------------------------------------
interface rgbh_pix_if import rgbh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  red_in;
	logic [CH_W-1:0]  green_in;
	logic [CH_W-1:0]  blue_in;
	logic [CH_W-1:0]  brightness_factor;
	logic [IDX_W-1:0] pixel_index;

	modport source (
		output valid, red_in, green_in, blue_in, brightness_factor, pixel_index,
		input  ready
	);
	modport sink (
		input  valid, red_in, green_in, blue_in, brightness_factor, pixel_index,
		output ready
	);
endinterface

interface rgbh_hsv_if import rgbh_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue_degrees;
	logic [SAT_W-1:0] saturation_pct;
	logic [VAL_W-1:0] scaled_value;
	logic [IDX_W-1:0] pixel_index_out;

	modport source (
		output valid, hue_degrees, saturation_pct, scaled_value, pixel_index_out,
		input  ready
	);
	modport sink (
		input  valid, hue_degrees, saturation_pct, scaled_value, pixel_index_out,
		output ready
	);
endinterface

// ===== hdl/rgb_to_hsv_pixel_top.sv =====
// an accepted pixel beat passes stage 1, stage 2, the divider stages and the output register
// throughput: one pixel per cycle while hsv.ready is high; each stage advances when empty or drained,
// so bubbles are squeezed out under output backpressure
// the 9-stage restoring divider sets the depth (one quotient bit per stage)
// reset clears the valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_top
// Pipelined rgb to hsv conversion with truncated hue, saturation and
// brightness scaled value.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top import rgbh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rgbh_pix_if.sink    pixel,
	rgbh_hsv_if.source  hsv
);

	typedef struct packed {
		logic [REM_W-1:0] hue_rem;
		logic [HUE_W-1:0] hue_quo;
		logic [CH_W-1:0]  hue_div;
		logic             hue_zero;
		logic [REM_W-1:0] sat_rem;
		logic [HUE_W-1:0] sat_quo;
		logic [CH_W-1:0]  sat_div;
		logic             sat_zero;
		logic [ACC_W-1:0] val_acc;
		logic [IDX_W-1:0] idx;
	} div_stage_t;

	// stage 1: max, spread, sector
	logic             v_s1;
	logic [CH_W-1:0]  mx_s1;
	logic [CH_W-1:0]  d_s1;
	sector_t          sec_s1;
	logic             neg_s1;
	logic [CH_W-1:0]  mag_s1;
	logic [CH_W-1:0]  br_s1;
	logic [IDX_W-1:0] idx_s1;

	// stage 2: dividends and brightness product
	logic             v_s2;
	div_stage_t       st_s2;

	// divider stages
	div_stage_t       dv_sx  [DIV_STEPS];
	logic             dv_v_sx[DIV_STEPS];
	div_stage_t       dv_src [DIV_STEPS+1];
	logic             dv_srcv[DIV_STEPS+1];
	div_stage_t       dv_nxt [DIV_STEPS];
	logic             en_dv  [DIV_STEPS];

	logic en_s1, en_s2, en_out;

	// output register
	logic             out_v_q;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] idx_q;

	// stall chain
	assign en_out = !out_v_q || hsv.ready;
	assign en_dv[DIV_STEPS-1] = !dv_v_sx[DIV_STEPS-1] || en_out;
	genvar e;
	generate
		for (e = 0; e < DIV_STEPS-1; e++) begin : g_en
			assign en_dv[e] = !dv_v_sx[e] || en_dv[e+1];
		end
	endgenerate
	assign en_s2 = !v_s2 || en_dv[0];
	assign en_s1 = !v_s1 || en_s2;
	assign pixel.ready = en_s1;

	// stage 1 logic
	logic [CH_W-1:0] r, g, b, mx_c, mn_c, x_c, y_c;
	sector_t         sec_c;

	always_comb begin
		r = pixel.red_in;
		g = pixel.green_in;
		b = pixel.blue_in;
		if (r >= g && r >= b) begin
			sec_c = SEC_RED;
			mx_c  = r;
			x_c   = g;
			y_c   = b;
		end else if (g >= b) begin
			sec_c = SEC_GREEN;
			mx_c  = g;
			x_c   = b;
			y_c   = r;
		end else begin
			sec_c = SEC_BLUE;
			mx_c  = b;
			x_c   = r;
			y_c   = g;
		end
		mn_c = (r < g) ? r : g;
		if (b < mn_c)
			mn_c = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mx_s1  <= mx_c;
			d_s1   <= mx_c - mn_c;
			sec_s1 <= sec_c;
			neg_s1 <= (x_c < y_c);
			mag_s1 <= (x_c < y_c) ? (y_c - x_c) : (x_c - y_c);
			br_s1  <= pixel.brightness_factor;
			idx_s1 <= pixel.pixel_index;
		end
	end

	// stage 2 logic
	logic [HUE_W-1:0] base_c;
	logic [REM_W-1:0] bd_c, sm_c;
	div_stage_t       st_c;

	always_comb begin
		case (sec_s1)
			SEC_RED:   base_c = BASE_RED;
			SEC_GREEN: base_c = BASE_GREEN;
			SEC_BLUE:  base_c = BASE_BLUE;
			default:   base_c = BASE_RED;
		endcase
		bd_c = REM_W'(base_c) * REM_W'(d_s1);
		sm_c = REM_W'(SIXTY) * REM_W'(mag_s1);
		st_c.hue_rem  = neg_s1 ? (bd_c - sm_c) : (bd_c + sm_c);
		st_c.hue_quo  = '0;
		st_c.hue_div  = d_s1;
		st_c.hue_zero = (d_s1 == '0);
		st_c.sat_rem  = REM_W'(d_s1) * REM_W'(PCT_SCALE);
		st_c.sat_quo  = '0;
		st_c.sat_div  = mx_s1;
		st_c.sat_zero = (mx_s1 == '0);
		st_c.val_acc  = ACC_W'(mx_s1) * ACC_W'(br_s1);
		st_c.idx      = idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			st_s2 <= st_c;
		end
	end

	// divider pipeline, one quotient bit per stage, msb first
	assign dv_src[0]  = st_s2;
	assign dv_srcv[0] = v_s2;

	genvar k;
	generate
		for (k = 0; k < DIV_STEPS; k++) begin : g_div
			localparam int SH = DIV_STEPS - 1 - k;

			logic [REM_W-1:0]  hd, sd;
			logic [PROD_W-1:0] recip;

			always_comb begin
				dv_nxt[k] = dv_src[k];
				hd = REM_W'(dv_src[k].hue_div) << SH;
				sd = REM_W'(dv_src[k].sat_div) << SH;
				recip = PROD_W'(dv_src[k].val_acc) * PROD_W'(DIV255_MUL);
				if (dv_src[k].hue_rem >= hd) begin
					dv_nxt[k].hue_rem     = dv_src[k].hue_rem - hd;
					dv_nxt[k].hue_quo[SH] = 1'b1;
				end
				if (dv_src[k].sat_rem >= sd) begin
					dv_nxt[k].sat_rem     = dv_src[k].sat_rem - sd;
					dv_nxt[k].sat_quo[SH] = 1'b1;
				end
				// value: scale by 100, then divide by 255 via reciprocal
				if (k == 0) begin
					dv_nxt[k].val_acc = dv_src[k].val_acc * ACC_W'(PCT_SCALE);
				end else if (k == 1) begin
					dv_nxt[k].val_acc = ACC_W'(recip >> DIV255_SHIFT);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_sx[k] <= 1'b0;
				end else if (en_dv[k]) begin
					dv_v_sx[k] <= dv_srcv[k];
				end
			end

			always_ff @(posedge clk) begin
				if (en_dv[k]) begin
					dv_sx[k] <= dv_nxt[k];
				end
			end

			assign dv_src[k+1]  = dv_sx[k];
			assign dv_srcv[k+1] = dv_v_sx[k];
		end
	endgenerate

	// output stage: hue wrap and zero cases
	div_stage_t       fin;
	logic [HUE_W-1:0] hue_c;

	always_comb begin
		fin = dv_src[DIV_STEPS];
		if (fin.hue_zero)
			hue_c = '0;
		else if (fin.hue_quo >= HUE_FULL)
			hue_c = fin.hue_quo - HUE_FULL;
		else
			hue_c = fin.hue_quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= dv_srcv[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			hue_q <= hue_c;
			sat_q <= fin.sat_zero ? '0 : fin.sat_quo[SAT_W-1:0];
			val_q <= fin.val_acc[VAL_W-1:0];
			idx_q <= fin.idx;
		end
	end

	assign hsv.valid           = out_v_q;
	assign hsv.hue_degrees     = hue_q;
	assign hsv.saturation_pct  = sat_q;
	assign hsv.scaled_value    = val_q;
	assign hsv.pixel_index_out = idx_q;

	// checks
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> hsv.hue_degrees < HUE_FULL)
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> hsv.saturation_pct <= SAT_W'(PCT_SCALE))
		else $error("saturation above 100");

	a_val_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> hsv.scaled_value <= 15'd25500)
		else $error("scaled value out of range");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv.valid |-> pixel.ready)
		else $error("input stalled with empty output register");

endmodule
